[hw/rtl/segment_closest_params_top_defines.svh]
// Assertion helpers for the top-level RTL file.
`ifndef SEGMENT_CLOSEST_PARAMS_TOP_DEFINES_SVH
`define SEGMENT_CLOSEST_PARAMS_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/scp_pkg.sv]
package scp_pkg;

    localparam int CFG_WIDTH = 20;

    typedef enum logic
    {
        REG_DEGENERATE_LEN = 1'b0,
        REG_PARALLEL_DEN   = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic valid;
        logic advance;
    } pipe_ctrl_t;

endpackage

[hw/rtl/scp_div.sv]
// Two-lane pipelined restoring divider: clamp(num/den) to [0,1], floor to
// FRAC_BITS fraction bits. One quotient bit per stage.
module scp_div import scp_pkg::*;
#(
    parameter int NUM_WIDTH = 58,
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pipe_ctrl_t                  ctrl,
    input  logic signed [NUM_WIDTH-1:0] num [2],
    input  logic signed [NUM_WIDTH-1:0] den [2],
    output logic                        q_valid,
    output logic [FRAC_BITS:0]          quo [2]
);

    logic                 v_reg    [0:FRAC_BITS];
    logic                 zero_reg [0:FRAC_BITS][0:1];
    logic                 sat_reg  [0:FRAC_BITS][0:1];
    logic [NUM_WIDTH-1:0] r_reg    [0:FRAC_BITS][0:1];
    logic [NUM_WIDTH-1:0] d_reg    [0:FRAC_BITS][0:1];
    logic [FRAC_BITS-1:0] q_reg    [0:FRAC_BITS][0:1];

    logic zero_next [2];
    logic sat_next  [2];

    // Entry: sort out negative numerators, non-positive denominators and saturated ratios up front.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            zero_next[l] = num[l][NUM_WIDTH-1] || den[l][NUM_WIDTH-1] || (den[l] == '0);
            sat_next[l]  = !zero_next[l] && (den[l] <= num[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            v_reg[0] <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int l = 0; l < 2; l++)
            begin
                zero_reg[0][l] <= zero_next[l];
                sat_reg[0][l]  <= sat_next[l];
                r_reg[0][l]    <= num[l];
                d_reg[0][l]    <= den[l];
                q_reg[0][l]    <= '0;
            end
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_step
        logic [NUM_WIDTH-1:0] r2     [2];
        logic                 ge     [2];
        logic [NUM_WIDTH-1:0] r_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                r2[l]     = {r_reg[k-1][l][NUM_WIDTH-2:0], 1'b0};
                ge[l]     = (d_reg[k-1][l] <= r2[l]);
                r_next[l] = ge[l] ? (r2[l] - d_reg[k-1][l]) : r2[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    zero_reg[k][l] <= zero_reg[k-1][l];
                    sat_reg[k][l]  <= sat_reg[k-1][l];
                    r_reg[k][l]    <= r_next[l];
                    d_reg[k][l]    <= d_reg[k-1][l];
                    q_reg[k][l]    <= {q_reg[k-1][l][FRAC_BITS-2:0], ge[l]};
                end
            end
        end
    end

    assign q_valid = v_reg[FRAC_BITS];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (zero_reg[FRAC_BITS][l])
                quo[l] = '0;
            else if (sat_reg[FRAC_BITS][l])
                quo[l] = {1'b1, {FRAC_BITS{1'b0}}};
            else
                quo[l] = {1'b0, q_reg[FRAC_BITS][l]};
        end
    end

endmodule

[hw/rtl/segment_closest_params_top.sv]
// Closest-point parameters of two 3D segments AB and CD.
// Input stream (s_tvalid/s_tready/s_tdata): one item carries the twelve
//   signed endpoint coordinates A, B, C, D (x, y, z each).
// Output stream (m_tvalid/m_tready/m_tdata): one item per input item with
//   s on AB and t on CD, unsigned Q1.PARAM_FRAC_BITS, each within [0, 1].
// APB port: 0x0 degenerate_length_sq, 0x4 parallel_denominator (20 bits);
//   write only while the stream is idle.
// Throughput: one item per cycle unless the output stalls; the quotient
//   pipeline of one bit per stage sets the depth, not the rate.
// Stall: the whole pipeline holds when the output register is full and
//   m_tready is low; s_tready drops in the same cycle, nothing is lost.
// Reset: clears all valid bits and both registers to 0; payload is not reset.
// Stages: differences, products, dot sums, split wide products, full
//   products, numerators, case select, then the divider.
`include "segment_closest_params_top_defines.svh"

module segment_closest_params_top import scp_pkg::*;
#(
    parameter int COORD_WIDTH     = 24,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // seg1_start_x, seg1_start_y, seg1_start_z, seg1_end_x, seg1_end_y,
    // seg1_end_z, seg2_start_x, seg2_start_y, seg2_start_z, seg2_end_x,
    // seg2_end_y, seg2_end_z (lowest bits first)
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // param_first, param_second (lowest bits first)
    output logic [((2*(PARAM_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = PARAM_FRAC_BITS;
    localparam int QW   = FB + 1;
    localparam int DW   = CW + 1;        // coordinate difference
    localparam int PRW  = 2 * DW;        // one coordinate product
    localparam int DOTW = 2 * DW + 2;    // dot product
    localparam int EW   = DOTW + 1;      // sums of two dots
    localparam int EPW  = DOTW + 2;      // endpoint squared distances
    localparam int HALF = DOTW / 2;
    localparam int PPW  = 2 * HALF + 2;  // partial product
    localparam int NUMW = 2 * DOTW + 2;  // products of dots and their sums
    localparam int OUT_W = ((2*QW+7)/8)*8;

    typedef struct packed
    {
        logic signed [PPW-1:0] hh;
        logic signed [PPW-1:0] hl;
        logic signed [PPW-1:0] lh;
        logic signed [PPW-1:0] ll;
    } part_t;

    function automatic part_t split_mul(input logic signed [DOTW-1:0] x,
                                        input logic signed [DOTW-1:0] y);
        logic signed [HALF:0] xh;
        logic signed [HALF:0] yh;
        logic signed [HALF:0] xl;
        logic signed [HALF:0] yl;
        part_t r;
        xh = $signed({x[DOTW-1], x[DOTW-1:HALF]});
        yh = $signed({y[DOTW-1], y[DOTW-1:HALF]});
        xl = $signed({1'b0, x[HALF-1:0]});
        yl = $signed({1'b0, y[HALF-1:0]});
        r.hh = PPW'(xh) * PPW'(yh);
        r.hl = PPW'(xh) * PPW'(yl);
        r.lh = PPW'(xl) * PPW'(yh);
        r.ll = PPW'(xl) * PPW'(yl);
        return r;
    endfunction

    function automatic logic signed [NUMW-1:0] join_mul(input part_t p);
        logic signed [NUMW-1:0] r;
        r = (NUMW'(p.hh) <<< (2*HALF)) + ((NUMW'(p.hl) + NUMW'(p.lh)) <<< HALF)
            + NUMW'(p.ll);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] deg_len_reg, par_den_reg;
    logic [CFG_WIDTH-1:0] deg_len_next, par_den_next;
    cfg_reg_t             cfg_sel;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        deg_len_next = deg_len_reg;
        par_den_next = par_den_reg;
        if (cfg_write)
        begin
            case (cfg_sel)
                REG_DEGENERATE_LEN: deg_len_next = pwdata[CFG_WIDTH-1:0];
                REG_PARALLEL_DEN:   par_den_next = pwdata[CFG_WIDTH-1:0];
                default:            deg_len_next = deg_len_reg;
            endcase
        end
        case (cfg_sel)
            REG_DEGENERATE_LEN: prdata = 32'(deg_len_reg);
            REG_PARALLEL_DEN:   prdata = 32'(par_den_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_len_reg <= '0;
            par_den_reg <= '0;
        end
        else
        begin
            deg_len_reg <= deg_len_next;
            par_den_reg <= par_den_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage advances together unless the output
    // register holds an item that is not taken.
    // ------------------------------------------------------------------
    logic       en;
    logic [7:1] v_reg;
    logic [7:1] v_next;
    logic       m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign v_next   = {v_reg[6:1], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: edge vectors AB, CD, AC
    // ------------------------------------------------------------------
    logic signed [CW-1:0] pa [3], pb [3], pc [3], pd [3];
    logic signed [DW-1:0] ab_next [3], cd_next [3], ac_next [3];
    logic signed [DW-1:0] ab_reg  [3], cd_reg  [3], ac_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = s_tdata[k*CW +: CW];
            pb[k] = s_tdata[(3+k)*CW +: CW];
            pc[k] = s_tdata[(6+k)*CW +: CW];
            pd[k] = s_tdata[(9+k)*CW +: CW];
            ab_next[k] = DW'(pb[k]) - DW'(pa[k]);
            cd_next[k] = DW'(pd[k]) - DW'(pc[k]);
            ac_next[k] = DW'(pc[k]) - DW'(pa[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg <= ab_next;
            cd_reg <= cd_next;
            ac_reg <= ac_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis products
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] p_a_next [3], p_b_next [3], p_c_next [3];
    logic signed [PRW-1:0] p_d_next [3], p_e_next [3], p_q_next [3];
    logic signed [PRW-1:0] p_a_reg  [3], p_b_reg  [3], p_c_reg  [3];
    logic signed [PRW-1:0] p_d_reg  [3], p_e_reg  [3], p_q_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_a_next[k] = PRW'(ab_reg[k]) * PRW'(ab_reg[k]);
            p_b_next[k] = PRW'(ab_reg[k]) * PRW'(cd_reg[k]);
            p_c_next[k] = PRW'(cd_reg[k]) * PRW'(cd_reg[k]);
            p_d_next[k] = PRW'(ac_reg[k]) * PRW'(ab_reg[k]);
            p_e_next[k] = PRW'(ac_reg[k]) * PRW'(cd_reg[k]);
            p_q_next[k] = PRW'(ac_reg[k]) * PRW'(ac_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg <= p_a_next;
            p_b_reg <= p_b_next;
            p_c_reg <= p_c_next;
            p_d_reg <= p_d_next;
            p_e_reg <= p_e_next;
            p_q_reg <= p_q_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dot products a, b, c, d, e and |AC|^2
    // ------------------------------------------------------------------
    function automatic logic signed [DOTW-1:0] sum3(input logic signed [PRW-1:0] p [3]);
        return DOTW'(p[0]) + DOTW'(p[1]) + DOTW'(p[2]);
    endfunction

    logic signed [DOTW-1:0] dot_a_reg, dot_b_reg, dot_c_reg, dot_d_reg, dot_e_reg, dot_q_reg;
    logic signed [DOTW-1:0] dot_a_next, dot_b_next, dot_c_next;
    logic signed [DOTW-1:0] dot_d_next, dot_e_next, dot_q_next;

    always_comb
    begin
        dot_a_next = sum3(p_a_reg);
        dot_b_next = sum3(p_b_reg);
        dot_c_next = sum3(p_c_reg);
        dot_d_next = sum3(p_d_reg);
        dot_e_next = sum3(p_e_reg);
        dot_q_next = sum3(p_q_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_a_reg <= dot_a_next;
            dot_b_reg <= dot_b_next;
            dot_c_reg <= dot_c_next;
            dot_d_reg <= dot_d_next;
            dot_e_reg <= dot_e_next;
            dot_q_reg <= dot_q_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: split wide products into half-width partials; degenerate
    // flags; endpoint distances from the dot products.
    // Products: 0 a*c, 1 b*b, 2 c*d, 3 b*e, 4 b*d, 5 a*e
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] thr_dot;
    part_t                  pt_next [6];
    part_t                  pt_reg  [6];
    logic signed [DOTW-1:0] a4_reg, c4_reg, d4_reg;
    logic signed [EW-1:0]   bd4_reg, ne4_reg, bme4_reg;
    logic signed [EW-1:0]   bd4_next, ne4_next, bme4_next;
    logic                   dga4_reg, dgc4_reg, dga4_next, dgc4_next;
    logic signed [EPW-1:0]  ac2_reg, ad2_reg, bc2_reg, bd2_reg;
    logic signed [EPW-1:0]  ac2_next, ad2_next, bc2_next, bd2_next;

    assign thr_dot = DOTW'(deg_len_reg);

    always_comb
    begin
        pt_next[0] = split_mul(dot_a_reg, dot_c_reg);
        pt_next[1] = split_mul(dot_b_reg, dot_b_reg);
        pt_next[2] = split_mul(dot_c_reg, dot_d_reg);
        pt_next[3] = split_mul(dot_b_reg, dot_e_reg);
        pt_next[4] = split_mul(dot_b_reg, dot_d_reg);
        pt_next[5] = split_mul(dot_a_reg, dot_e_reg);
        bd4_next  = EW'(dot_b_reg) + EW'(dot_d_reg);
        ne4_next  = -EW'(dot_e_reg);
        bme4_next = EW'(dot_b_reg) - EW'(dot_e_reg);
        dga4_next = (dot_a_reg <= thr_dot);
        dgc4_next = (dot_c_reg <= thr_dot);
        // AD = AC + CD, BC = AC - AB, BD = AC + CD - AB
        ac2_next = EPW'(dot_q_reg);
        ad2_next = EPW'(dot_q_reg) + (EPW'(dot_e_reg) <<< 1) + EPW'(dot_c_reg);
        bc2_next = EPW'(dot_q_reg) - (EPW'(dot_d_reg) <<< 1) + EPW'(dot_a_reg);
        bd2_next = EPW'(dot_q_reg) + EPW'(dot_c_reg) + EPW'(dot_a_reg)
                   + (EPW'(dot_e_reg) <<< 1) - (EPW'(dot_d_reg) <<< 1)
                   - (EPW'(dot_b_reg) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg   <= pt_next;
            a4_reg   <= dot_a_reg;
            c4_reg   <= dot_c_reg;
            d4_reg   <= dot_d_reg;
            bd4_reg  <= bd4_next;
            ne4_reg  <= ne4_next;
            bme4_reg <= bme4_next;
            dga4_reg <= dga4_next;
            dgc4_reg <= dgc4_next;
            ac2_reg  <= ac2_next;
            ad2_reg  <= ad2_next;
            bc2_reg  <= bc2_next;
            bd2_reg  <= bd2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: full products, range checks for the parallel case and the
    // nearest endpoint pair (ties go to AC, then AD, then BC).
    // ------------------------------------------------------------------
    logic signed [NUMW-1:0] fp_next [6];
    logic signed [NUMW-1:0] fp_reg  [6];
    logic signed [DOTW-1:0] a5_reg, c5_reg, d5_reg;
    logic signed [EW-1:0]   bd5_reg, ne5_reg, bme5_reg;
    logic                   dga5_reg, dgc5_reg;
    logic                   iu_ca_next, iu_cb_next, iu_d_next;
    logic                   iu_ca_reg, iu_cb_reg, iu_d_reg;
    logic                   end_s_next, end_t_next, end_s_reg, end_t_reg;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
            fp_next[j] = join_mul(pt_reg[j]);
        iu_ca_next = !ne4_reg[EW-1] && (ne4_reg <= EW'(c4_reg));
        iu_cb_next = !bme4_reg[EW-1] && (bme4_reg <= EW'(c4_reg));
        iu_d_next  = !d4_reg[DOTW-1] && (d4_reg <= a4_reg);
        if ((ac2_reg <= ad2_reg) && (ac2_reg <= bc2_reg) && (ac2_reg <= bd2_reg))
        begin
            end_s_next = 1'b0;
            end_t_next = 1'b0;
        end
        else if ((ad2_reg <= bc2_reg) && (ad2_reg <= bd2_reg))
        begin
            end_s_next = 1'b0;
            end_t_next = 1'b1;
        end
        else if (bc2_reg <= bd2_reg)
        begin
            end_s_next = 1'b1;
            end_t_next = 1'b0;
        end
        else
        begin
            end_s_next = 1'b1;
            end_t_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fp_reg    <= fp_next;
            a5_reg    <= a4_reg;
            c5_reg    <= c4_reg;
            d5_reg    <= d4_reg;
            bd5_reg   <= bd4_reg;
            ne5_reg   <= ne4_reg;
            bme5_reg  <= bme4_reg;
            dga5_reg  <= dga4_reg;
            dgc5_reg  <= dgc4_reg;
            iu_ca_reg <= iu_ca_next;
            iu_cb_reg <= iu_cb_next;
            iu_d_reg  <= iu_d_next;
            end_s_reg <= end_s_next;
            end_t_reg <= end_t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: determinant (floored at zero) and the two numerators
    // ------------------------------------------------------------------
    logic signed [NUMW-1:0] denom_next, snum_next, tnum_next, diff_ab;
    logic signed [NUMW-1:0] denom_reg, snum_reg, tnum_reg;
    logic signed [DOTW-1:0] a6_reg, c6_reg, d6_reg;
    logic signed [EW-1:0]   bd6_reg, ne6_reg, bme6_reg;
    logic                   dga6_reg, dgc6_reg, iu_ca6_reg, iu_cb6_reg, iu_d6_reg;
    logic                   end_s6_reg, end_t6_reg;

    always_comb
    begin
        diff_ab    = fp_reg[0] - fp_reg[1];
        denom_next = diff_ab[NUMW-1] ? '0 : diff_ab;
        snum_next  = fp_reg[2] - fp_reg[3];
        tnum_next  = fp_reg[4] - fp_reg[5];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denom_reg  <= denom_next;
            snum_reg   <= snum_next;
            tnum_reg   <= tnum_next;
            a6_reg     <= a5_reg;
            c6_reg     <= c5_reg;
            d6_reg     <= d5_reg;
            bd6_reg    <= bd5_reg;
            ne6_reg    <= ne5_reg;
            bme6_reg   <= bme5_reg;
            dga6_reg   <= dga5_reg;
            dgc6_reg   <= dgc5_reg;
            iu_ca6_reg <= iu_ca_reg;
            iu_cb6_reg <= iu_cb_reg;
            iu_d6_reg  <= iu_d_reg;
            end_s6_reg <= end_s_reg;
            end_t6_reg <= end_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: pick numerator and denominator for each parameter. A fixed
    // 0 is 0/1 and a fixed 1 is 1/1, so the divider serves every case.
    // ------------------------------------------------------------------
    localparam logic signed [NUMW-1:0] N_ZERO = '0;
    localparam logic signed [NUMW-1:0] N_ONE  = NUMW'(1);

    logic signed [NUMW-1:0] pthr;
    logic                   t_in, par;
    logic signed [NUMW-1:0] num_next [2], den_next [2];
    logic signed [NUMW-1:0] num_reg  [2], den_reg  [2];

    assign pthr = NUMW'(par_den_reg);

    always_comb
    begin
        t_in = !tnum_reg[NUMW-1] && (tnum_reg <= denom_reg);
        par  = (denom_reg <= pthr);
        num_next[0] = N_ZERO;
        den_next[0] = N_ONE;
        num_next[1] = N_ZERO;
        den_next[1] = N_ONE;
        if (dga6_reg)
        begin
            // first segment is a point: project A onto CD
            if (!dgc6_reg)
            begin
                num_next[1] = NUMW'(ne6_reg);
                den_next[1] = NUMW'(c6_reg);
            end
        end
        else if (dgc6_reg)
        begin
            num_next[0] = NUMW'(d6_reg);
            den_next[0] = NUMW'(a6_reg);
        end
        else if (par)
        begin
            if (iu_ca6_reg)
            begin
                num_next[1] = NUMW'(ne6_reg);
                den_next[1] = NUMW'(c6_reg);
            end
            else if (iu_cb6_reg)
            begin
                num_next[0] = N_ONE;
                num_next[1] = NUMW'(bme6_reg);
                den_next[1] = NUMW'(c6_reg);
            end
            else if (iu_d6_reg)
            begin
                num_next[0] = NUMW'(d6_reg);
                den_next[0] = NUMW'(a6_reg);
            end
            else
            begin
                num_next[0] = end_s6_reg ? N_ONE : N_ZERO;
                num_next[1] = end_t6_reg ? N_ONE : N_ZERO;
            end
        end
        else if (t_in)
        begin
            num_next[0] = snum_reg;
            den_next[0] = denom_reg;
            num_next[1] = tnum_reg;
            den_next[1] = denom_reg;
        end
        else if (tnum_reg[NUMW-1])
        begin
            num_next[0] = NUMW'(d6_reg);
            den_next[0] = NUMW'(a6_reg);
        end
        else
        begin
            num_next[0] = NUMW'(bd6_reg);
            den_next[0] = NUMW'(a6_reg);
            num_next[1] = N_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider and output register
    // ------------------------------------------------------------------
    pipe_ctrl_t      div_ctrl;
    logic            div_valid;
    logic [QW-1:0]   div_quo [2];
    logic [QW-1:0]   first_reg, second_reg;

    assign div_ctrl.valid   = v_reg[7];
    assign div_ctrl.advance = en;

    scp_div #(
        .NUM_WIDTH (NUMW),
        .FRAC_BITS (FB)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (div_ctrl),
        .num     (num_reg),
        .den     (den_reg),
        .q_valid (div_valid),
        .quo     (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first_reg  <= div_quo[0];
            second_reg <= div_quo[1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({second_reg, first_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SCP_ASSERT_IMPLIES(a_len_nonneg, v_reg[3],
        !dot_a_reg[DOTW-1] && !dot_c_reg[DOTW-1], "squared length went negative")
    `SCP_ASSERT_IMPLIES(a_div_den_pos, v_reg[7],
        !den_reg[0][NUMW-1] && (den_reg[0] != '0) && !den_reg[1][NUMW-1] && (den_reg[1] != '0),
        "divider got a non-positive denominator")
    `SCP_ASSERT_NEXT(a_stall_hold, m_valid_reg && !m_tready,
        $stable(v_reg) && m_valid_reg, "pipeline moved during a stall")
    `SCP_ASSERT_IMPLIES(a_param_range, m_valid_reg,
        (first_reg <= QW'(1 << FB)) && (second_reg <= QW'(1 << FB)),
        "parameter above one")

endmodule
